[src/lfra_pkg.sv]
package lfra_pkg;

    localparam int REQ_TIME_W = 20;
    localparam int ROOM_OUT_W = 7;
    localparam int FIN_OUT_W  = 40;
    localparam int CFG_W      = 8;

    typedef struct packed {
        logic [REQ_TIME_W-1:0] start_time;
        logic [REQ_TIME_W-1:0] end_time;
    } t_req;

    typedef struct packed {
        logic [ROOM_OUT_W-1:0] room;
        logic [FIN_OUT_W-1:0]  finish_time;
        logic [ROOM_OUT_W-1:0] busiest_room;
        logic                  time_saturated;
    } t_res;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_PICK,
        ST_COUNT,
        ST_DONE
    } t_state;

endpackage

[src/lfra_store.sv]
module lfra_store #(
    parameter int MAX_ROOMS  = 128,
    parameter int TIME_BITS  = 40,
    parameter int COUNT_BITS = 20,
    parameter int ROOM_W     = 7
) (
    input  logic                  i_clk,
    input  logic [ROOM_W-1:0]     i_busy_rd_addr,
    output logic [TIME_BITS-1:0]  o_busy_rd_data,
    input  logic [ROOM_W-1:0]     i_cnt_rd_addr,
    output logic [COUNT_BITS-1:0] o_cnt_rd_data,
    input  logic                  i_wr_en,
    input  logic [ROOM_W-1:0]     i_wr_addr,
    input  logic [TIME_BITS-1:0]  i_wr_busy,
    input  logic [COUNT_BITS-1:0] i_wr_cnt
);

    logic [TIME_BITS-1:0]  r_busy_mem [MAX_ROOMS];
    logic [COUNT_BITS-1:0] r_cnt_mem  [MAX_ROOMS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_busy_mem[i_wr_addr] <= i_wr_busy;
            r_cnt_mem[i_wr_addr]  <= i_wr_cnt;
        end
        o_busy_rd_data <= r_busy_mem[i_busy_rd_addr];
        o_cnt_rd_data  <= r_cnt_mem[i_cnt_rd_addr];
    end

endmodule

[src/lfra_scan.sv]
module lfra_scan #(
    parameter int TIME_BITS = 40,
    parameter int ROOM_W    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_vld,
    input  logic [ROOM_W-1:0]    i_idx,
    input  logic [TIME_BITS-1:0] i_busy,
    input  logic [TIME_BITS-1:0] i_start_time,
    output logic [ROOM_W-1:0]    o_pick,
    output logic [TIME_BITS-1:0] o_base
);

    logic                 r_found, n_found;
    logic                 r_first, n_first;
    logic [ROOM_W-1:0]    r_free_idx, n_free_idx;
    logic [TIME_BITS-1:0] r_min, n_min;
    logic [ROOM_W-1:0]    r_min_idx, n_min_idx;
    logic                 free_hit;
    logic                 min_hit;

    // shared compare unit: one room per cycle
    assign free_hit = (i_busy <= i_start_time);
    assign min_hit  = (i_busy < r_min);

    always_comb begin
        n_found    = r_found;
        n_first    = r_first;
        n_free_idx = r_free_idx;
        n_min      = r_min;
        n_min_idx  = r_min_idx;
        if (i_start) begin
            n_found = 1'b0;
            n_first = 1'b1;
        end else if (i_vld) begin
            if (!r_found && free_hit) begin
                n_found    = 1'b1;
                n_free_idx = i_idx;
            end
            if (r_first || min_hit) begin
                n_min     = i_busy;
                n_min_idx = i_idx;
            end
            n_first = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_found <= n_found;
            r_first <= n_first;
        end
        r_free_idx <= n_free_idx;
        r_min      <= n_min;
        r_min_idx  <= n_min_idx;
    end

    assign o_pick = r_found ? r_free_idx : r_min_idx;
    assign o_base = r_found ? i_start_time : r_min;

endmodule

[src/lowest_free_room_allocator.sv]
// requests are taken only in the idle state, so a new request waits until the previous
// result has been loaded into the output register
// the room table is scanned one room per cycle through one memory read port
// reset: synchronous active low; a clearing pass zeroes the room table,
// requests are stalled until it ends, config writes are taken always
module lowest_free_room_allocator #(
    parameter int MAX_ROOMS  = 128,
    parameter int TIME_BITS  = 40,
    parameter int COUNT_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_stall,
    input  lfra_pkg::t_req            i_req,
    output logic                      o_res_valid,
    input  logic                      i_res_stall,
    output lfra_pkg::t_res            o_res,
    input  logic                      i_cfg_wr_en,
    input  logic [lfra_pkg::CFG_W-1:0] i_cfg_wr_data
);

    import lfra_pkg::*;

    localparam int ROOM_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROOMS + 1);
    localparam int N_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int FX_W   = TIME_BITS + FIN_OUT_W;
    localparam int RX_W   = ROOM_W + ROOM_OUT_W;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_num_rooms;
    logic [ROOM_W-1:0]     r_idx, n_idx;
    logic [ROOM_W-1:0]     r_last, n_last;
    logic                  r_rd_vld;
    logic [ROOM_W-1:0]     r_rd_idx;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic [REQ_TIME_W-1:0] r_dur, n_dur;
    logic [ROOM_W-1:0]     r_pick, n_pick;
    logic [TIME_BITS-1:0]  r_base, n_base;
    logic [TIME_BITS-1:0]  r_fin, n_fin;
    logic                  r_sat, n_sat;
    logic [ROOM_W-1:0]     r_best_room, n_best_room;
    logic [COUNT_BITS-1:0] r_best_cnt, n_best_cnt;
    logic                  r_res_vld, n_res_vld;
    t_res                  r_res, n_res;

    logic                  req_acc;
    logic                  scan_start;
    logic [N_W-1:0]        num_ext;
    logic [N_W-1:0]        active;
    logic [ROOM_W-1:0]     scan_pick;
    logic [TIME_BITS-1:0]  scan_base;
    logic [TIME_BITS-1:0]  busy_rd;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic                  wr_en;
    logic [ROOM_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0]  wr_busy;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [TIME_BITS:0]    fin_sum;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [FX_W-1:0]       fin_ext;
    logic [RX_W-1:0]       pick_ext;
    logic [RX_W-1:0]       best_ext;

    assign o_req_stall = (r_state != ST_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign scan_start  = req_acc;
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

    // clamp room count to 1..MAX_ROOMS
    assign num_ext = N_W'(r_num_rooms);
    always_comb begin
        priority if (num_ext == '0) begin
            active = N_W'(1);
        end else if (num_ext > N_W'(MAX_ROOMS)) begin
            active = N_W'(MAX_ROOMS);
        end else begin
            active = num_ext;
        end
    end

    assign fin_sum = {1'b0, r_base} + (TIME_BITS + 1)'(r_dur);
    assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

    assign fin_ext  = FX_W'(r_fin);
    assign pick_ext = RX_W'(r_pick);
    assign best_ext = RX_W'(r_best_room);

    lfra_store #(
        .MAX_ROOMS  (MAX_ROOMS),
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS),
        .ROOM_W     (ROOM_W)
    ) u_store (
        .i_clk          (i_clk),
        .i_busy_rd_addr (r_idx),
        .o_busy_rd_data (busy_rd),
        .i_cnt_rd_addr  (scan_pick),
        .o_cnt_rd_data  (cnt_rd),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_busy      (wr_busy),
        .i_wr_cnt       (wr_cnt)
    );

    lfra_scan #(
        .TIME_BITS (TIME_BITS),
        .ROOM_W    (ROOM_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_vld        (r_rd_vld),
        .i_idx        (r_rd_idx),
        .i_busy       (busy_rd),
        .i_start_time (r_start),
        .o_pick       (scan_pick),
        .o_base       (scan_base)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last      = r_last;
        n_start     = r_start;
        n_dur       = r_dur;
        n_pick      = r_pick;
        n_base      = r_base;
        n_fin       = r_fin;
        n_sat       = r_sat;
        n_best_room = r_best_room;
        n_best_cnt  = r_best_cnt;
        n_res_vld   = r_res_vld && i_res_stall;
        n_res       = r_res;
        wr_en       = 1'b0;
        wr_addr     = r_pick;
        wr_busy     = '0;
        wr_cnt      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                if (r_idx == ROOM_W'(MAX_ROOMS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (req_acc) begin
                    n_start = TIME_BITS'(i_req.start_time);
                    n_dur   = (i_req.end_time > i_req.start_time) ?
                              i_req.end_time - i_req.start_time : '0;
                    n_last  = ROOM_W'(active - 1'b1);
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_last) begin
                    n_state = ST_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TAIL: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                n_pick  = scan_pick;
                n_base  = scan_base;
                n_state = ST_COUNT;
            end
            ST_COUNT: begin
                n_sat   = fin_sum[TIME_BITS];
                n_fin   = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
                wr_en   = 1'b1;
                wr_busy = n_fin;
                wr_cnt  = cnt_inc;
                priority if (cnt_inc > r_best_cnt) begin
                    n_best_cnt  = cnt_inc;
                    n_best_room = r_pick;
                end else if (cnt_inc == r_best_cnt && r_pick < r_best_room) begin
                    n_best_room = r_pick;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_res_vld || !i_res_stall) begin
                    n_res_vld                = 1'b1;
                    n_res.room               = pick_ext[ROOM_OUT_W-1:0];
                    n_res.finish_time        = fin_ext[FIN_OUT_W-1:0];
                    n_res.busiest_room       = best_ext[ROOM_OUT_W-1:0];
                    n_res.time_saturated     = r_sat;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_num_rooms <= CFG_W'(1);
            r_rd_vld    <= 1'b0;
            r_best_room <= '0;
            r_best_cnt  <= '0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            if (i_cfg_wr_en) begin
                r_num_rooms <= i_cfg_wr_data;
            end
            r_rd_vld    <= (r_state == ST_SCAN);
            r_best_room <= n_best_room;
            r_best_cnt  <= n_best_cnt;
            r_res_vld   <= n_res_vld;
        end
        r_rd_idx <= r_idx;
        r_last   <= n_last;
        r_start  <= n_start;
        r_dur    <= n_dur;
        r_pick   <= n_pick;
        r_base   <= n_base;
        r_fin    <= n_fin;
        r_sat    <= n_sat;
        r_res    <= n_res;
    end

endmodule

[bench/tb_lowest_free_room_allocator.sv]
module tb_lowest_free_room_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    class room_booking_ledger;
        logic [39:0] busy_until [128];
        logic [19:0] use_count [128];
        logic [6:0]  busiest;
        logic [19:0] busiest_count;
        logic [7:0]  room_setting;
        lfra_pkg::t_res pending_grants [$];
        int errors;
        int checked;

        function new();
            for (int i = 0; i < 128; i++) begin
                busy_until[i] = '0;
                use_count[i]  = '0;
            end
            busiest       = '0;
            busiest_count = '0;
            room_setting  = 8'd1;
            errors        = 0;
            checked       = 0;
        endfunction

        function void set_rooms(logic [7:0] v);
            room_setting = v;
        endfunction

        function int outstanding();
            return pending_grants.size();
        endfunction

        function void book(lfra_pkg::t_req r);
            logic [40:0] dur;
            logic [40:0] fin;
            logic [39:0] base;
            logic [19:0] cnt;
            int active;
            int pick;
            bit found;
            lfra_pkg::t_res grant;
            dur = (r.end_time > r.start_time) ? {21'b0, r.end_time - r.start_time} : '0;
            active = (room_setting == 0) ? 1 :
                     ((room_setting > 128) ? 128 : int'(room_setting));
            found = 1'b0;
            pick = 0;
            for (int i = 0; i < active; i++) begin
                if (!found && busy_until[i] <= {20'b0, r.start_time}) begin
                    pick = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                base = {20'b0, r.start_time};
            end else begin
                for (int i = 1; i < active; i++) begin
                    if (busy_until[i] < busy_until[pick]) pick = i;
                end
                base = busy_until[pick];
            end
            fin = {1'b0, base} + dur;
            grant.time_saturated = fin[40];
            if (fin[40]) fin = {1'b0, {40{1'b1}}};
            busy_until[pick] = fin[39:0];
            cnt = use_count[pick];
            if (cnt != '1) cnt = cnt + 1'b1;
            use_count[pick] = cnt;
            if (cnt > busiest_count) begin
                busiest_count = cnt;
                busiest = 7'(pick);
            end else if (cnt == busiest_count && pick < busiest) begin
                busiest = 7'(pick);
            end
            grant.room         = 7'(pick);
            grant.finish_time  = fin[39:0];
            grant.busiest_room = busiest;
            pending_grants.push_back(grant);
        endfunction

        function void note_mismatch(string field, logic [39:0] want, logic [39:0] got);
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        endfunction

        function void check_grant(lfra_pkg::t_res got);
            lfra_pkg::t_res want;
            if (pending_grants.size() == 0) begin
                note_mismatch("unexpected transaction, room", '0, 40'(got.room));
                return;
            end
            want = pending_grants.pop_front();
            checked++;
            if (got.room !== want.room)
                note_mismatch("room", 40'(want.room), 40'(got.room));
            if (got.finish_time !== want.finish_time)
                note_mismatch("finish_time", want.finish_time, got.finish_time);
            if (got.busiest_room !== want.busiest_room)
                note_mismatch("busiest_room", 40'(want.busiest_room), 40'(got.busiest_room));
            if (got.time_saturated !== want.time_saturated)
                note_mismatch("time_saturated", 40'(want.time_saturated),
                              40'(got.time_saturated));
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1_000_000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_req_valid = 1'b0;
    lfra_pkg::t_req i_req = '0;
    logic           i_res_stall = 1'b0;
    logic           i_cfg_wr_en = 1'b0;
    logic [lfra_pkg::CFG_W-1:0] i_cfg_wr_data = '0;
    logic           o_req_stall;
    logic           o_res_valid;
    lfra_pkg::t_res o_res;

    room_booking_ledger ledger;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int requests_sent = 0;
    int results_taken = 0;
    int settings_used = 0;
    int cycle_count = 0;

    lowest_free_room_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req         (i_req),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_res         (o_res),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_lowest_free_room_allocator: done, errors");
            $finish;
        end
    end

    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            // long hold-off lets the request side back up
            if (results_taken == 150 || results_taken == 900) hold = 300;
            else hold = rx_quiet ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_res_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_res_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_res_valid !== 1'b1);
            ledger.check_grant(o_res);
            results_taken++;
        end
    end

    task automatic offer_request(input logic [19:0] s, input logic [19:0] e);
        int gap;
        lfra_pkg::t_req r;
        r.start_time = s;
        r.end_time   = e;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (o_req_stall !== 1'b0);
        ledger.book(r);
        requests_sent++;
    endtask

    task automatic set_room_count(input logic [7:0] v);
        i_req_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        ledger.set_rooms(v);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random_phase(input logic [7:0] setting, input int count);
        int active;
        int step_max;
        int dur_max;
        int roll;
        int dur;
        int cursor;
        logic [19:0] s;
        logic [19:0] e;
        set_room_count(setting);
        active = (setting == 0) ? 1 : ((setting > 128) ? 128 : int'(setting));
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        step_max = $urandom_range(1, 300);
        dur_max = step_max * (active + 1) * 2;
        if (dur_max > 200000) dur_max = 200000;
        cursor = $urandom_range(0, 20'hC0000);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                // ordered starts, durations long enough to contend for rooms
                cursor += $urandom_range(0, step_max);
                if (cursor > 20'hFFFFF) cursor = $urandom_range(0, 1000);
                dur = $urandom_range(1, dur_max);
                s = cursor[19:0];
                e = (cursor + dur > 20'hFFFFF) ? 20'hFFFFF : 20'(cursor + dur);
            end else if (roll < 93) begin
                s = cursor[19:0];
                e = 20'($urandom_range(0, cursor));
            end else begin
                s = 20'($urandom);
                e = 20'($urandom);
            end
            offer_request(s, e);
        end
    endtask

    initial begin : stimulus
        logic [7:0] plan [16];
        ledger = new();
        plan = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd16, 8'd5, 8'd0,
                 8'd128, 8'd7, 8'd200, 8'd32, 8'd255, 8'd2, 8'd64, 8'd1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single room after reset
        offer_request(20'd0, 20'd0);
        offer_request(20'd0, 20'd10);
        offer_request(20'd5, 20'd20);
        offer_request(20'd30, 20'd30);
        offer_request(20'd100, 20'd50);
        offer_request(20'hFFFFF, 20'hFFFFF);
        offer_request(20'd0, 20'hFFFFF);
        set_room_count(8'd0);
        offer_request(20'd1, 20'd2);
        set_room_count(8'd4);
        offer_request(20'd0, 20'hFFFFF);
        offer_request(20'd0, 20'd5);
        offer_request(20'd2, 20'd3);
        offer_request(20'd3, 20'd9);
        set_room_count(8'd255);
        offer_request(20'd7, 20'd8);
        offer_request(20'd7, 20'd8);
        set_room_count(8'd128);
        offer_request(20'd8, 20'hFFFFF);
        set_room_count(8'd2);
        offer_request(20'd9, 20'd10);
        offer_request(20'd9, 20'd10);
        set_room_count(8'd200);
        offer_request(20'd10, 20'd12);

        foreach (plan[i]) begin
            run_random_phase(plan[i], (plan[i] >= 64) ? 45 : 105);
        end

        i_req_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("covered %0d requests over %0d room settings, %0d results compared",
                 requests_sent, settings_used, ledger.checked);
        $display("settings included 0, 1, 128 and above 128; %0d mismatches", ledger.errors);
        if (ledger.errors == 0) begin
            $display("tb_lowest_free_room_allocator: done, clean");
        end else begin
            $display("tb_lowest_free_room_allocator: done, errors");
        end
        $finish;
    end

endmodule
